[hdl/umrb_pkg.sv]
package umrb_pkg;

   localparam int TX_DEPTH = 128;
   localparam int RX_DEPTH = 128;

   localparam int TX_PTR_W = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
   localparam int RX_PTR_W = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
   localparam int TX_CNT_W = $clog2(TX_DEPTH + 1);
   localparam int RX_CNT_W = $clog2(RX_DEPTH + 1);

   localparam int BYTE_W  = 8;
   localparam int OP_W    = 2;
   localparam int LEVEL_W = 8;

   typedef logic [TX_PTR_W-1:0] tx_ptr_type;
   typedef logic [RX_PTR_W-1:0] rx_ptr_type;
   typedef logic [TX_CNT_W-1:0] tx_cnt_type;
   typedef logic [RX_CNT_W-1:0] rx_cnt_type;

   typedef enum logic [OP_W-1:0] {
      OP_WRITE = 2'd0,
      OP_READ  = 2'd1,
      OP_SEND  = 2'd2,
      OP_RECV  = 2'd3
   } op_type;

   typedef struct packed {
      logic [OP_W-1:0]   operation;
      logic [BYTE_W-1:0] data_byte;
      logic              frame_start;
      logic              ninth_bit;
      logic              keep_frame;
   } req_payload_type;

   typedef struct packed {
      logic                op_done;
      logic [BYTE_W-1:0]   read_byte;
      logic                line_send;
      logic [BYTE_W-1:0]   line_byte;
      logic                line_ninth;
      logic                tx_idle;
      logic                tx_drained;
      logic                rx_started;
      logic [LEVEL_W-1:0]  tx_level;
      logic [LEVEL_W-1:0]  rx_level;
   } rsp_payload_type;

   typedef struct packed {
      logic capture;
      logic execute;
      logic load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_hold;
   } ctrl_status_type;

   function automatic tx_ptr_type tx_ptr_next(input tx_ptr_type ptr);
      if (ptr == tx_ptr_type'(TX_DEPTH - 1)) begin
         return '0;
      end
      return ptr + tx_ptr_type'(1);
   endfunction

   function automatic rx_ptr_type rx_ptr_next(input rx_ptr_type ptr);
      if (ptr == rx_ptr_type'(RX_DEPTH - 1)) begin
         return '0;
      end
      return ptr + rx_ptr_type'(1);
   endfunction

endpackage

[hdl/umrb_req_if.sv]
interface umrb_req_if;
   import umrb_pkg::*;

   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   operation;
   logic [BYTE_W-1:0] data_byte;
   logic              frame_start;
   logic              ninth_bit;
   logic              keep_frame;

   modport source (
      output valid, operation, data_byte, frame_start, ninth_bit, keep_frame,
      input  ready
   );

   modport sink (
      input  valid, operation, data_byte, frame_start, ninth_bit, keep_frame,
      output ready
   );
endinterface

[hdl/umrb_rsp_if.sv]
interface umrb_rsp_if;
   import umrb_pkg::*;

   logic               valid;
   logic               ready;
   logic               op_done;
   logic [BYTE_W-1:0]  read_byte;
   logic               line_send;
   logic [BYTE_W-1:0]  line_byte;
   logic               line_ninth;
   logic               tx_idle;
   logic               tx_drained;
   logic               rx_started;
   logic [LEVEL_W-1:0] tx_level;
   logic [LEVEL_W-1:0] rx_level;

   modport source (
      output valid, op_done, read_byte, line_send, line_byte, line_ninth,
             tx_idle, tx_drained, rx_started, tx_level, rx_level,
      input  ready
   );

   modport sink (
      input  valid, op_done, read_byte, line_send, line_byte, line_ninth,
             tx_idle, tx_drained, rx_started, tx_level, rx_level,
      output ready
   );
endinterface

[hdl/umrb_ctrl.sv]
module umrb_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  umrb_pkg::ctrl_status_type  status,
   output umrb_pkg::ctrl_cmd_type     cmd
);
   import umrb_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EXEC = 3'b010,
      ST_LOAD = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      req_ready   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.execute = 1'b1;
            state_in    = ST_LOAD;
         end
         ST_LOAD: begin
            if (!status.out_hold) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_capture_then_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> cmd.execute)
      else $error("Captured item was not executed in the next cycle.");

   a_exec_then_load_state: assert property (@(posedge clock) disable iff (reset)
      cmd.execute |=> (state_ff == ST_LOAD))
      else $error("Execution was not followed by the result load state.");

   a_no_load_while_held: assert property (@(posedge clock) disable iff (reset)
      status.out_hold |-> !cmd.load)
      else $error("Result register was overwritten before its transfer.");

endmodule

[hdl/umrb_dpath.sv]
module umrb_dpath (
   input  logic                       clock,
   input  logic                       reset,
   input  umrb_pkg::ctrl_cmd_type     cmd,
   output umrb_pkg::ctrl_status_type  status,
   input  umrb_pkg::req_payload_type  req_payload,
   input  logic                       csr_we,
   input  logic                       csr_wdata,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output umrb_pkg::rsp_payload_type  rsp_payload
);
   import umrb_pkg::*;

   req_payload_type  item_ff;

   logic [BYTE_W:0]   tx_mem [TX_DEPTH];
   logic [BYTE_W-1:0] rx_mem [RX_DEPTH];
   logic [BYTE_W:0]   tx_rd_ff;
   logic [BYTE_W-1:0] rx_rd_ff;

   tx_ptr_type tx_head_ff, tx_tail_ff;
   tx_cnt_type tx_count_ff;
   rx_ptr_type rx_head_ff, rx_tail_ff;
   rx_cnt_type rx_count_ff;
   logic       skip_ff;
   logic       mode_ff;

   logic               st_op_done_ff;
   logic               st_read_ff;
   logic               st_send_ff;
   logic               st_ninth_en_ff;
   logic               st_idle_ff;
   logic               st_drained_ff;
   logic               st_started_ff;
   logic [LEVEL_W-1:0] st_tx_level_ff;
   logic [LEVEL_W-1:0] st_rx_level_ff;

   rsp_payload_type out_ff;
   logic            out_valid_ff;

   op_type     op;
   logic       tx_full, tx_empty, rx_full, rx_empty;
   logic       wr_ok, rd_ok, send_ok, idle_hit, rx_ok;
   logic       recv_drop, skip_in;
   tx_cnt_type tx_count_in;
   rx_cnt_type rx_count_in;

   always_comb begin
      op        = op_type'(item_ff.operation);
      tx_full   = (tx_count_ff == tx_cnt_type'(TX_DEPTH));
      tx_empty  = (tx_count_ff == '0);
      rx_full   = (rx_count_ff == rx_cnt_type'(RX_DEPTH));
      rx_empty  = (rx_count_ff == '0);
      wr_ok     = (op == OP_WRITE) && !tx_full;
      rd_ok     = (op == OP_READ) && !rx_empty;
      send_ok   = (op == OP_SEND) && !tx_empty;
      idle_hit  = (op == OP_SEND) && tx_empty;
      recv_drop = mode_ff && skip_ff && !item_ff.ninth_bit;
      rx_ok     = (op == OP_RECV) && !recv_drop && !rx_full;
      skip_in   = skip_ff;
      if ((op == OP_RECV) && mode_ff && !recv_drop) begin
         skip_in = !item_ff.keep_frame;
      end
      tx_count_in = tx_count_ff;
      if (wr_ok) begin
         tx_count_in = tx_count_ff + tx_cnt_type'(1);
      end else if (send_ok) begin
         tx_count_in = tx_count_ff - tx_cnt_type'(1);
      end
      rx_count_in = rx_count_ff;
      if (rx_ok) begin
         rx_count_in = rx_count_ff + rx_cnt_type'(1);
      end else if (rd_ok) begin
         rx_count_in = rx_count_ff - rx_cnt_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff <= req_payload;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute && wr_ok) begin
         tx_mem[tx_tail_ff] <= {item_ff.frame_start, item_ff.data_byte};
      end
      if (cmd.execute) begin
         tx_rd_ff <= tx_mem[tx_head_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute && rx_ok) begin
         rx_mem[rx_tail_ff] <= item_ff.data_byte;
      end
      if (cmd.execute) begin
         rx_rd_ff <= rx_mem[rx_head_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_head_ff  <= '0;
         tx_tail_ff  <= '0;
         tx_count_ff <= '0;
         rx_head_ff  <= '0;
         rx_tail_ff  <= '0;
         rx_count_ff <= '0;
         skip_ff     <= 1'b0;
         mode_ff     <= 1'b0;
      end else if (csr_we) begin
         mode_ff <= csr_wdata;
         skip_ff <= csr_wdata;
      end else if (cmd.execute) begin
         tx_count_ff <= tx_count_in;
         rx_count_ff <= rx_count_in;
         skip_ff     <= skip_in;
         if (wr_ok) begin
            tx_tail_ff <= tx_ptr_next(tx_tail_ff);
         end
         if (send_ok) begin
            tx_head_ff <= tx_ptr_next(tx_head_ff);
         end
         if (rx_ok) begin
            rx_tail_ff <= rx_ptr_next(rx_tail_ff);
         end
         if (rd_ok) begin
            rx_head_ff <= rx_ptr_next(rx_head_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         st_op_done_ff  <= wr_ok || rd_ok;
         st_read_ff     <= rd_ok;
         st_send_ff     <= send_ok;
         st_ninth_en_ff <= send_ok && mode_ff;
         st_idle_ff     <= idle_hit;
         st_drained_ff  <= send_ok && (tx_count_ff == tx_cnt_type'(1));
         st_started_ff  <= rx_ok && rx_empty;
         st_tx_level_ff <= LEVEL_W'(tx_count_in);
         st_rx_level_ff <= LEVEL_W'(rx_count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         out_ff.op_done    <= st_op_done_ff;
         out_ff.read_byte  <= st_read_ff ? rx_rd_ff : '0;
         out_ff.line_send  <= st_send_ff;
         out_ff.line_byte  <= st_send_ff ? tx_rd_ff[BYTE_W-1:0] : '0;
         out_ff.line_ninth <= st_ninth_en_ff && tx_rd_ff[BYTE_W];
         out_ff.tx_idle    <= st_idle_ff;
         out_ff.tx_drained <= st_drained_ff;
         out_ff.rx_started <= st_started_ff;
         out_ff.tx_level   <= st_tx_level_ff;
         out_ff.rx_level   <= st_rx_level_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign status.out_hold = out_valid_ff && !rsp_ready;
   assign rsp_valid       = out_valid_ff;
   assign rsp_payload     = out_ff;

   a_tx_count_bound: assert property (@(posedge clock) disable iff (reset)
      tx_count_ff <= tx_cnt_type'(TX_DEPTH))
      else $error("Transmit fill count exceeds the queue depth.");

   a_rx_count_bound: assert property (@(posedge clock) disable iff (reset)
      rx_count_ff <= rx_cnt_type'(RX_DEPTH))
      else $error("Receive fill count exceeds the queue depth.");

   a_drained_needs_send: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.tx_drained |-> out_ff.line_send && (out_ff.tx_level == '0))
      else $error("Drain flag without a send that emptied the transmit queue.");

   a_idle_excludes_send: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !(out_ff.tx_idle && (out_ff.line_send || out_ff.op_done)))
      else $error("Idle report combined with another completed operation.");

endmodule

[hdl/uart_multidrop_ring_buffers_unit.sv]
// Buffered serial port core with a transmit queue and a receive queue of 128 bytes each
// and 9-bit multidrop framing. Each request transfer carries one operation (host write,
// host read, line ready to send, byte received from the line) and produces exactly one
// response transfer with the outcome and both queue levels. The request is captured,
// then the pointers and counters are updated and the queue memories are read, and then the
// response register is loaded. A new request is taken only once the previous one is
// loaded; the load waits while the previous response has not been transferred, and
// the next request is taken while a response still waits. Write the multidrop mode
// register through csr_we only while no item is in flight; the block does not enforce
// this. A write also sets the receive skip flag to the written value.
module uart_multidrop_ring_buffers_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic         csr_wdata,
   umrb_req_if.sink     req_ch,
   umrb_rsp_if.source   rsp_ch
);
   import umrb_pkg::*;

   ctrl_cmd_type     cmd;
   ctrl_status_type  status;
   req_payload_type  req_payload;
   rsp_payload_type  rsp_payload;

   assign req_payload.operation   = req_ch.operation;
   assign req_payload.data_byte   = req_ch.data_byte;
   assign req_payload.frame_start = req_ch.frame_start;
   assign req_payload.ninth_bit   = req_ch.ninth_bit;
   assign req_payload.keep_frame  = req_ch.keep_frame;

   umrb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   umrb_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_payload (req_payload),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .rsp_valid   (rsp_ch.valid),
      .rsp_ready   (rsp_ch.ready),
      .rsp_payload (rsp_payload)
   );

   assign rsp_ch.op_done    = rsp_payload.op_done;
   assign rsp_ch.read_byte  = rsp_payload.read_byte;
   assign rsp_ch.line_send  = rsp_payload.line_send;
   assign rsp_ch.line_byte  = rsp_payload.line_byte;
   assign rsp_ch.line_ninth = rsp_payload.line_ninth;
   assign rsp_ch.tx_idle    = rsp_payload.tx_idle;
   assign rsp_ch.tx_drained = rsp_payload.tx_drained;
   assign rsp_ch.rx_started = rsp_payload.rx_started;
   assign rsp_ch.tx_level   = rsp_payload.tx_level;
   assign rsp_ch.rx_level   = rsp_payload.rx_level;

endmodule
